>>> hw/rtl/cpu6502_subset_executor_assert.svh
// Assertion macros for the 6502 subset executor.
// Expect clk and arst_n in the scope of every use.
`ifndef CPU6502_SUBSET_EXECUTOR_ASSERT_SVH
`define CPU6502_SUBSET_EXECUTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CPU65SE_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define CPU65SE_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> hw/rtl/cpu65se_pkg.sv
// Shared types and constants for the 6502 subset executor.
// No dependencies.
`timescale 1ns / 1ps

package cpu65se_pkg;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_OP,
		ST_OPND1,
		ST_OPND2,
		ST_PUSH_HI,
		ST_PUSH_LO,
		ST_LOAD,
		ST_DONE
	} state_t;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_EXEC  = 2'd2;

	localparam logic [7:0] OP_LDA_IMM = 8'hA9;
	localparam logic [7:0] OP_LDA_ZP  = 8'hA5;
	localparam logic [7:0] OP_LDA_ZPX = 8'hB5;
	localparam logic [7:0] OP_STA_ZP  = 8'h85;
	localparam logic [7:0] OP_LDX_IMM = 8'hA2;
	localparam logic [7:0] OP_LDX_ZP  = 8'hA6;
	localparam logic [7:0] OP_LDX_ZPI = 8'hB6;
	localparam logic [7:0] OP_LDX_ABS = 8'hAE;
	localparam logic [7:0] OP_JSR     = 8'h20;

	localparam logic [15:0] PC_RESET   = 16'hFFFC;
	localparam logic [7:0]  SP_RESET   = 8'hFF;
	localparam logic [7:0]  STACK_PAGE = 8'h01;
	localparam logic [7:0]  ZERO_PAGE  = 8'h00;

	function automatic logic op_known(input logic [7:0] op);
		return op inside {OP_LDA_IMM, OP_LDA_ZP, OP_LDA_ZPX, OP_STA_ZP, OP_LDX_IMM,
			OP_LDX_ZP, OP_LDX_ZPI, OP_LDX_ABS, OP_JSR};
	endfunction

endpackage

>>> hw/rtl/cpu65se_ram.sv
// Generic single-port RAM, one write or read per cycle, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cpu65se_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/cpu6502_subset_executor.sv
// 6502 subset executor: sequencer, architectural registers and one shared adder.
// Depends on cpu65se_pkg, cpu65se_ram and cpu6502_subset_executor_assert.svh.
// States per request: host write or unused command IDLE, DONE; host read IDLE, RD, DONE;
// unknown opcode IDLE, OP, DONE; immediate load or STA IDLE, OP, OPND1, DONE; zero-page load
// adds LOAD; LDX abs IDLE, OP, OPND1, OPND2, LOAD, DONE; JSR adds OPND2, PUSH_HI, PUSH_LO.
// The next request is taken in the first cycle the result is valid. The single-port memory,
// one access per cycle, sets these steps. After reset a pass clears memory, taking no request.
`timescale 1ns / 1ps
`include "cpu6502_subset_executor_assert.svh"

module cpu6502_subset_executor #(
	parameter int MEM_DEPTH = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // mem_addr[15:0], mem_wdata[23:16]
	input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata   // acc, index_x, prog_counter, stack_ptr,
	                                   // zero_flag, negative_flag, read_data,
	                                   // unknown_opcode, zero pad
);

	import cpu65se_pkg::*;

	localparam int AW = $clog2(MEM_DEPTH);
	localparam logic [AW-1:0] CLR_LAST = AW'(MEM_DEPTH - 1);

	state_t state_q, state_d;
	logic [AW-1:0] clr_q;
	logic [7:0]  acc_q, x_q, sp_q;
	logic [15:0] pc_q;
	logic        z_q, n_q;
	logic [7:0]  op_q, lo_q, tgt_hi_q, rdata_q;
	logic [15:0] ret_q;
	logic        unk_q;
	logic        m_tvalid_q;
	logic [55:0] m_tdata_q;

	logic        ram_we;
	logic [15:0] ram_addr16;
	logic [7:0]  ram_wdata, ram_rdata;
	logic [15:0] alu_a, alu_b, alu_sum;
	logic        out_free, accept;
	logic [15:0] s_addr;
	logic [7:0]  s_wdata;

	assign s_addr  = s_axis_tdata[15:0];
	assign s_wdata = s_axis_tdata[23:16];
	assign out_free = !m_tvalid_q || m_axis_tready;
	assign accept = s_axis_tvalid && s_axis_tready;

	cpu65se_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr16[AW-1:0]),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// shared adder: PC increment, indexed address, PC-1, SP decrement
	assign alu_sum = alu_a + alu_b;

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		ram_we        = 1'b0;
		ram_addr16    = pc_q;
		ram_wdata     = acc_q;
		alu_a         = pc_q;
		alu_b         = 16'd1;
		case (state_q)
			ST_CLEAR: begin
				ram_we     = 1'b1;
				ram_addr16 = 16'(clr_q);
				ram_wdata  = 8'd0;
				if (clr_q == CLR_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					case (s_axis_tuser)
						CMD_WRITE: begin
							ram_we     = 1'b1;
							ram_addr16 = s_addr;
							ram_wdata  = s_wdata;
							state_d    = ST_DONE;
						end
						CMD_READ: begin
							ram_addr16 = s_addr;
							state_d    = ST_RD;
						end
						CMD_EXEC: state_d = ST_OP;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_RD: state_d = ST_DONE;
			ST_OP: begin
				// fetch the operand while the opcode decodes
				state_d = op_known(ram_rdata) ? ST_OPND1 : ST_DONE;
			end
			ST_OPND1: begin
				case (op_q)
					OP_LDA_ZP, OP_LDX_ZP: begin
						ram_addr16 = {ZERO_PAGE, ram_rdata};
						state_d    = ST_LOAD;
					end
					OP_LDA_ZPX, OP_LDX_ZPI: begin
						alu_a      = {8'd0, ram_rdata};
						alu_b      = {8'd0, x_q};
						ram_addr16 = {ZERO_PAGE, alu_sum[7:0]};
						state_d    = ST_LOAD;
					end
					OP_STA_ZP: begin
						ram_we     = 1'b1;
						ram_addr16 = {ZERO_PAGE, ram_rdata};
						state_d    = ST_DONE;
					end
					OP_LDX_ABS, OP_JSR: state_d = ST_OPND2;
					default: state_d = ST_DONE;
				endcase
			end
			ST_OPND2: begin
				if (op_q == OP_LDX_ABS) begin
					ram_addr16 = {ram_rdata, lo_q};
					state_d    = ST_LOAD;
				end else begin
					alu_b   = 16'hFFFF;
					state_d = ST_PUSH_HI;
				end
			end
			ST_PUSH_HI: begin
				ram_we     = 1'b1;
				ram_addr16 = {STACK_PAGE, sp_q};
				ram_wdata  = ret_q[15:8];
				alu_a      = {8'd0, sp_q};
				alu_b      = 16'hFFFF;
				state_d    = ST_PUSH_LO;
			end
			ST_PUSH_LO: begin
				ram_we     = 1'b1;
				ram_addr16 = {STACK_PAGE, sp_q};
				ram_wdata  = ret_q[7:0];
				alu_a      = {8'd0, sp_q};
				alu_b      = 16'hFFFF;
				state_d    = ST_DONE;
			end
			ST_LOAD: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			acc_q      <= 8'd0;
			x_q        <= 8'd0;
			pc_q       <= PC_RESET;
			sp_q       <= SP_RESET;
			z_q        <= 1'b0;
			n_q        <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: begin
					if (accept && s_axis_tuser == CMD_EXEC) pc_q <= alu_sum;
				end
				ST_OP: begin
					if (op_known(ram_rdata)) pc_q <= alu_sum;
				end
				ST_OPND1: begin
					case (op_q)
						OP_LDA_IMM: begin
							acc_q <= ram_rdata;
							z_q   <= (ram_rdata == 8'd0);
							n_q   <= ram_rdata[7];
						end
						OP_LDX_IMM: begin
							x_q <= ram_rdata;
							z_q <= (ram_rdata == 8'd0);
							n_q <= ram_rdata[7];
						end
						OP_LDX_ABS, OP_JSR: pc_q <= alu_sum;
						default: ;
					endcase
				end
				ST_PUSH_HI: sp_q <= alu_sum[7:0];
				ST_PUSH_LO: begin
					sp_q <= alu_sum[7:0];
					pc_q <= {tgt_hi_q, lo_q};
				end
				ST_LOAD: begin
					if (op_q inside {OP_LDA_ZP, OP_LDA_ZPX}) begin
						acc_q <= ram_rdata;
					end else begin
						x_q <= ram_rdata;
					end
					z_q <= (ram_rdata == 8'd0);
					n_q <= ram_rdata[7];
				end
				default: ;
			endcase
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					rdata_q <= 8'd0;
					unk_q   <= 1'b0;
				end
			end
			ST_RD: rdata_q <= ram_rdata;
			ST_OP: begin
				op_q <= ram_rdata;
				if (!op_known(ram_rdata)) unk_q <= 1'b1;
			end
			ST_OPND1: lo_q <= ram_rdata;
			ST_OPND2: begin
				tgt_hi_q <= ram_rdata;
				ret_q    <= alu_sum;
			end
			ST_DONE: begin
				if (out_free) begin
					m_tdata_q <= {5'd0, unk_q, rdata_q, n_q, z_q, sp_q, pc_q, x_q, acc_q};
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	`CPU65SE_ASSERT_NEXT(a_jsr_sp_step, state_q == ST_PUSH_LO, sp_q == $past(sp_q) - 8'd1, "SP did not fall on JSR low push")
	`CPU65SE_ASSERT_NEXT(a_host_keeps_pc, accept && s_axis_tuser != CMD_EXEC, pc_q == $past(pc_q), "host request moved PC")
	`CPU65SE_ASSERT_NEXT(a_done_posts, state_q == ST_DONE && out_free, m_axis_tvalid && state_q == ST_IDLE, "result not posted")
	`CPU65SE_ASSERT_NOW(a_no_take_busy, state_q != ST_IDLE, !s_axis_tready, "request taken while busy")

endmodule
